/* rtl/obd_pkg.sv */
// ----------------------------------------------------------------------------
// obd_pkg
// Shared types, register indexes and protocol constants of the speed poller.
// ----------------------------------------------------------------------------
package obd_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REQUEST_INTERVAL = 3'd0,
        REG_REPLY_TIMEOUT    = 3'd1,
        REG_FRESH_WINDOW     = 3'd2,
        REG_REPLY_ID         = 3'd3,
        REG_REPLY_ID_MASK    = 3'd4,
        REG_WANTED_PID       = 3'd5
    } t_reg_idx;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_FRAME = 1'b1;

    localparam logic [7:0] SVC_REPLY_CODE = 8'h41;
    localparam logic [7:0] SF_LEN_SPEED   = 8'h03;
    localparam logic [3:0] MIN_FRAME_LEN  = 4'd4;

    localparam logic [15:0] RST_REQUEST_INTERVAL = 16'd100;
    localparam logic [15:0] RST_REPLY_TIMEOUT    = 16'd50;
    localparam logic [15:0] RST_FRESH_WINDOW     = 16'd1000;
    localparam logic [10:0] RST_REPLY_ID         = 11'h7E8;
    localparam logic [10:0] RST_REPLY_ID_MASK    = 11'h7F8;
    localparam logic [7:0]  RST_WANTED_PID       = 8'h0D;

    typedef struct packed {
        logic [15:0] request_interval_ms;
        logic [15:0] reply_timeout_ms;
        logic [15:0] fresh_window_ms;
        logic [10:0] reply_id;
        logic [10:0] reply_id_mask;
        logic [7:0]  wanted_pid;
    } t_cfg;

    typedef struct packed {
        logic        mode;
        logic [31:0] time_ms;
        logic [10:0] frame_id;
        logic [3:0]  frame_len;
        logic [7:0]  byte_zero;
        logic [7:0]  byte_one;
        logic [7:0]  byte_two;
        logic [7:0]  byte_three;
    } t_in_item;

    typedef struct packed {
        logic        request_now;
        logic        frame_taken;
        logic [7:0]  speed_value;
        logic        speed_valid;
        logic [31:0] speed_time;
        logic        awaiting_reply;
        logic        responding;
    } t_out_item;

endpackage

/* rtl/obd_in_if.sv */
// ----------------------------------------------------------------------------
// obd_in_if
// Input item channel: tick events and received frames.
// ----------------------------------------------------------------------------
interface obd_in_if;
    logic               valid;
    logic               ready;
    obd_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/obd_out_if.sv */
// ----------------------------------------------------------------------------
// obd_out_if
// Result item channel: request pulse and held speed status.
// ----------------------------------------------------------------------------
interface obd_out_if;
    logic               valid;
    logic               ready;
    obd_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/obd_cfg_if.sv */
// ----------------------------------------------------------------------------
// obd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface obd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [obd_pkg::CFG_IDX_W-1:0]      index;
    logic [obd_pkg::CFG_DATA_W-1:0]     wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

/* rtl/obd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// obd_cfg_regs
// Configuration register file, written one register per transaction.
// ----------------------------------------------------------------------------
module obd_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    obd_cfg_if.sink         i_cfg,
    output obd_pkg::t_cfg   o_cfg
);

    obd_pkg::t_cfg r_cfg;
    obd_pkg::t_cfg n_cfg;
    logic          w_wr;

    assign i_cfg.ready = 1'b1;
    assign w_wr = i_cfg.valid;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (obd_pkg::t_reg_idx'(i_cfg.index))
                obd_pkg::REG_REQUEST_INTERVAL: n_cfg.request_interval_ms = i_cfg.wdata;
                obd_pkg::REG_REPLY_TIMEOUT:    n_cfg.reply_timeout_ms = i_cfg.wdata;
                obd_pkg::REG_FRESH_WINDOW:     n_cfg.fresh_window_ms = i_cfg.wdata;
                obd_pkg::REG_REPLY_ID:         n_cfg.reply_id = i_cfg.wdata[10:0];
                obd_pkg::REG_REPLY_ID_MASK:    n_cfg.reply_id_mask = i_cfg.wdata[10:0];
                obd_pkg::REG_WANTED_PID:       n_cfg.wanted_pid = i_cfg.wdata[7:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.request_interval_ms <= obd_pkg::RST_REQUEST_INTERVAL;
            r_cfg.reply_timeout_ms    <= obd_pkg::RST_REPLY_TIMEOUT;
            r_cfg.fresh_window_ms     <= obd_pkg::RST_FRESH_WINDOW;
            r_cfg.reply_id            <= obd_pkg::RST_REPLY_ID;
            r_cfg.reply_id_mask       <= obd_pkg::RST_REPLY_ID_MASK;
            r_cfg.wanted_pid          <= obd_pkg::RST_WANTED_PID;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/obd_eval.sv */
// ----------------------------------------------------------------------------
// obd_eval
// Poller state and its single-pass update for one tick or frame.
// ----------------------------------------------------------------------------
module obd_eval (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  obd_pkg::t_in_item   i_item,
    input  obd_pkg::t_cfg       i_cfg,
    output obd_pkg::t_out_item  o_result
);

    logic [31:0] r_last_req;
    logic [31:0] r_last_reply;
    logic [7:0]  r_speed;
    logic        r_held_valid;
    logic        r_waiting;

    logic [31:0] n_last_req;
    logic [31:0] n_last_reply;
    logic [7:0]  n_speed;
    logic        n_held_valid;
    logic        n_waiting;

    logic [31:0] w_req_age;
    logic [31:0] w_reply_age;
    logic        w_is_tick;
    logic        w_due;
    logic        w_timed_out;
    logic        w_id_hit;
    logic        w_taken;
    logic        w_fresh;

    assign w_is_tick   = (i_item.mode == obd_pkg::MODE_TICK);
    assign w_req_age   = i_item.time_ms - r_last_req;
    assign w_reply_age = i_item.time_ms - r_last_reply;
    assign w_due       = w_is_tick && (w_req_age >= {16'd0, i_cfg.request_interval_ms});
    assign w_timed_out = w_req_age > {16'd0, i_cfg.reply_timeout_ms};

    assign w_id_hit = (i_item.frame_id & i_cfg.reply_id_mask)
                   == (i_cfg.reply_id & i_cfg.reply_id_mask);
    assign w_taken  = !w_is_tick && w_id_hit
                   && (i_item.frame_len >= obd_pkg::MIN_FRAME_LEN)
                   && (i_item.byte_zero == obd_pkg::SF_LEN_SPEED)
                   && (i_item.byte_one == obd_pkg::SVC_REPLY_CODE)
                   && (i_item.byte_two == i_cfg.wanted_pid);

    always_comb begin
        n_last_req   = w_due ? i_item.time_ms : r_last_req;
        n_last_reply = w_taken ? i_item.time_ms : r_last_reply;
        n_speed      = w_taken ? i_item.byte_three : r_speed;
        n_held_valid = r_held_valid || w_taken;
        if (w_is_tick) begin
            n_waiting = w_due || (r_waiting && !w_timed_out);
        end else begin
            n_waiting = r_waiting && !w_taken;
        end
    end

    // a fresh reply has age zero
    assign w_fresh = w_taken ? (i_cfg.fresh_window_ms != 16'd0)
                             : (r_held_valid && (w_reply_age < {16'd0, i_cfg.fresh_window_ms}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_req   <= '0;
            r_last_reply <= '0;
            r_speed      <= '0;
            r_held_valid <= 1'b0;
            r_waiting    <= 1'b0;
        end else if (i_en) begin
            r_last_req   <= n_last_req;
            r_last_reply <= n_last_reply;
            r_speed      <= n_speed;
            r_held_valid <= n_held_valid;
            r_waiting    <= n_waiting;
        end
    end

    always_comb begin
        o_result.request_now    = w_due;
        o_result.frame_taken    = w_taken;
        o_result.speed_value    = n_speed;
        o_result.speed_valid    = n_held_valid;
        o_result.speed_time     = n_last_reply;
        o_result.awaiting_reply = n_waiting;
        o_result.responding     = w_fresh;
    end

endmodule

/* rtl/obd2_speed_poller.sv */
// ----------------------------------------------------------------------------
// obd2_speed_poller
// OBD-II mode 01 vehicle speed poller with request pacing and reply timeout.
// ----------------------------------------------------------------------------
// Channels: i_in takes one item per transaction, either a millisecond tick
// (mode 0) or a received CAN frame (mode 1). o_out returns exactly one status
// item per input item, in order: request pulse, frame taken flag, held speed,
// its timestamp, valid, awaiting reply and responding. i_cfg writes one
// register per transaction and is always ready; write it only while idle.
// Pipeline: each i_in item passes the input register, then the result
// register, before o_out valid rises for it. Throughput: one item per
// cycle while o_out is taken; the state update is a single pass of
// 32-bit subtract and compare logic.
// Reset: synchronous active low; both pipeline stages empty, held speed and
// timestamps cleared, registers at their default values.
// Stall: while o_out is not taken the result register holds, the input
// register fills, and then i_in.ready drops until o_out drains.
// ----------------------------------------------------------------------------
module obd2_speed_poller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    obd_in_if.sink      i_in,
    obd_cfg_if.sink     i_cfg,
    obd_out_if.source   o_out
);

    obd_pkg::t_cfg      w_cfg;
    obd_pkg::t_out_item w_result;

    logic               r_in_valid;
    obd_pkg::t_in_item  r_in_item;
    logic               r_out_valid;
    obd_pkg::t_out_item r_out_item;

    logic               w_adv;
    logic               w_fire;

    assign w_adv  = !r_out_valid || o_out.ready;
    assign w_fire = r_in_valid && w_adv;
    assign i_in.ready = !r_in_valid || w_adv;

    obd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    obd_eval u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_fire),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_item <= i_in.data;
        end
        if (w_fire) begin
            r_out_item <= w_result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

endmodule
